[rtl/core/omp_pkg.sv]
package omp_pkg;

  // Defaults for the top-level parameters
  localparam int MaxPacketDef  = 4096;
  localparam int AddrBytesDef  = 256;
  localparam int TagBytesDef   = 64;
  localparam int MaxArgsDef    = 8;
  localparam int StringKeepDef = 255;

  // Fixed field widths
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int ARG_W   = 3;
  localparam int ERR_W   = 3;
  // Wide enough for a run of skipped tags at the largest argument count
  localparam int SKIP_W  = 6;

  // Entries in the queue between parser and result sequencer
  localparam int QueueDepth = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_F     = 8'h66;
  localparam logic [7:0] CHAR_S     = 8'h73;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDR_CHAR = 3'd0,
    KIND_INT       = 3'd1,
    KIND_FLOAT     = 3'd2,
    KIND_STR_CHAR  = 3'd3,
    KIND_STR_END   = 3'd4,
    KIND_SKIPPED   = 3'd5,
    KIND_OK        = 3'd6,
    KIND_ERROR     = 3'd7
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_ADDR_LONG = 3'd1,
    ERR_NO_TAG    = 3'd2,
    ERR_NO_COMMA  = 3'd3,
    ERR_TAG_LONG  = 3'd4,
    ERR_TAG_SHORT = 3'd5,
    ERR_ARG_SHORT = 3'd6
  } err_e;

  // Everything one byte produces: one primary result, a run of skipped-tag
  // markers, and the end-of-datagram status, in that order.
  typedef struct packed {
    logic               has_prim;
    kind_e              prim_kind;
    logic [VALUE_W-1:0] prim_value;
    logic [ARG_W-1:0]   prim_arg;
    logic [ARG_W-1:0]   skip_start;
    logic [SKIP_W-1:0]  skip_cnt;
    logic               has_status;
    err_e               status;
  } omp_event_t;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [ARG_W-1:0]   arg_index;
    err_e               error_code;
    logic               last_result;
  } omp_result_t;

endpackage

[rtl/core/omp_front.sv]
module omp_front
  import omp_pkg::*;
#(
  parameter int MAX_PACKET  = MaxPacketDef,
  parameter int ADDR_BYTES  = AddrBytesDef,
  parameter int TAG_BYTES   = TagBytesDef,
  parameter int MAX_ARGS    = MaxArgsDef,
  parameter int STRING_KEEP = StringKeepDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_packet_i,
  output omp_event_t ev_o,
  output logic       ev_valid_o
);

  localparam int PW  = $clog2(MAX_PACKET + 5);
  localparam int TTW = $clog2(TAG_BYTES);
  localparam int CW  = $clog2(MAX_ARGS + 1);
  localparam int FLW = $clog2(STRING_KEEP + 1);

  typedef enum logic [7:0] {
    PH_ADDR     = 8'b0000_0001,
    PH_ADDR_PAD = 8'b0000_0010,
    PH_TAG      = 8'b0000_0100,
    PH_TAG_PAD  = 8'b0000_1000,
    PH_WORD     = 8'b0001_0000,
    PH_STR      = 8'b0010_0000,
    PH_STR_PAD  = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PW-1:0]    bp_q, bp_d;
  logic [PW-1:0]    req_q, req_d;
  logic [FLW-1:0]   fl_q, fl_d;
  logic [TTW-1:0]   tag_total_q, tag_total_d;
  logic [CW-1:0]    tag_count_q, tag_count_d;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic [23:0]      gather_q, gather_d;
  err_e             err_q, err_d;
  logic [MAX_ARGS-1:0] skip_q, skip_d;
  logic [MAX_ARGS-1:0] str_q, str_d;
  logic [MAX_ARGS-1:0] float_q, float_d;

  logic             work;
  logic [PW-1:0]    bp_inc;
  logic [PW-1:0]    need;
  logic             aligned;
  logic [CW-1:0]    na_base;
  logic [CW-1:0]    na_found;
  logic             na_found_str;
  logic [CW-1:0]    na_cnt;
  phase_e           na_phase;
  logic [PW-1:0]    na_req;
  logic             cur_float;
  omp_event_t       ev;

  assign bp_inc  = bp_q + PW'(1);
  assign need    = bp_inc + PW'(4);
  assign aligned = (bp_inc[1:0] == 2'b00);
  assign work    = (err_q == ERR_NONE) && (32'(bp_q) < 32'(MAX_PACKET));

  // Walk past skipped tags: words and strings advance from the next slot
  always_comb begin
    na_base = ((phase_q == PH_WORD) || (phase_q == PH_STR)) ? cursor_q + CW'(1) : cursor_q;
    na_found     = CW'(MAX_ARGS);
    na_found_str = 1'b0;
    for (int i = MAX_ARGS - 1; i >= 0; i--) begin
      if ((32'(i) >= 32'(na_base)) &&
          ((32'(i) >= 32'(tag_count_q)) || !skip_q[i])) begin
        na_found     = CW'(i);
        na_found_str = str_q[i];
      end
    end
    na_cnt = na_found - na_base;
    if (na_found < tag_count_q) begin
      na_phase = na_found_str ? PH_STR : PH_WORD;
    end else begin
      na_phase = PH_DONE;
    end
    na_req = ((na_cnt != '0) && (need > req_q)) ? need : req_q;
  end

  always_comb begin
    cur_float = 1'b0;
    for (int i = 0; i < MAX_ARGS; i++) begin
      if (CW'(i) == cursor_q) begin
        cur_float = float_q[i];
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    bp_d        = bp_q;
    req_d       = req_q;
    fl_d        = fl_q;
    tag_total_d = tag_total_q;
    tag_count_d = tag_count_q;
    cursor_d    = cursor_q;
    gather_d    = gather_q;
    err_d       = err_q;
    skip_d      = skip_q;
    str_d       = str_q;
    float_d     = float_q;
    ev          = '0;
    ev.prim_kind = KIND_ADDR_CHAR;
    ev.status    = ERR_NONE;

    if (work) begin
      bp_d = bp_inc;
      case (phase_q)
        PH_ADDR: begin
          if (in_byte_i == CHAR_NUL) begin
            phase_d = aligned ? PH_TAG : PH_ADDR_PAD;
          end else if (32'(bp_inc) >= 32'(ADDR_BYTES)) begin
            err_d = ERR_ADDR_LONG;
          end else begin
            ev.has_prim   = 1'b1;
            ev.prim_kind  = KIND_ADDR_CHAR;
            ev.prim_value = VALUE_W'(in_byte_i);
          end
        end
        PH_ADDR_PAD: begin
          if (aligned) begin
            phase_d = PH_TAG;
          end
        end
        PH_TAG: begin
          if (tag_total_q == '0) begin
            if (in_byte_i != CHAR_COMMA) begin
              err_d = ERR_NO_COMMA;
            end else begin
              tag_total_d = TTW'(1);
            end
          end else if (in_byte_i == CHAR_NUL) begin
            if (aligned) begin
              phase_d  = na_phase;
              cursor_d = na_found;
              req_d    = na_req;
              fl_d     = '0;
              gather_d = '0;
              ev.skip_start = ARG_W'(na_base);
              ev.skip_cnt   = SKIP_W'(na_cnt);
            end else begin
              phase_d = PH_TAG_PAD;
            end
          end else if (tag_total_q >= TTW'(TAG_BYTES - 1)) begin
            err_d = ERR_TAG_LONG;
          end else begin
            if (32'(tag_count_q) < 32'(MAX_ARGS)) begin
              for (int i = 0; i < MAX_ARGS; i++) begin
                if (CW'(i) == tag_count_q) begin
                  skip_d[i]  = (in_byte_i != CHAR_I) && (in_byte_i != CHAR_F) &&
                               (in_byte_i != CHAR_S);
                  str_d[i]   = (in_byte_i == CHAR_S);
                  float_d[i] = (in_byte_i == CHAR_F);
                end
              end
              tag_count_d = tag_count_q + CW'(1);
            end
            tag_total_d = tag_total_q + TTW'(1);
          end
        end
        PH_WORD: begin
          if (fl_q < FLW'(3)) begin
            gather_d = {gather_q[15:0], in_byte_i};
            fl_d     = fl_q + FLW'(1);
          end else begin
            ev.has_prim   = 1'b1;
            ev.prim_kind  = cur_float ? KIND_FLOAT : KIND_INT;
            ev.prim_value = {gather_q, in_byte_i};
            ev.prim_arg   = ARG_W'(cursor_q);
            phase_d  = na_phase;
            cursor_d = na_found;
            req_d    = na_req;
            fl_d     = '0;
            gather_d = '0;
            ev.skip_start = ARG_W'(na_base);
            ev.skip_cnt   = SKIP_W'(na_cnt);
          end
        end
        PH_STR: begin
          if (in_byte_i == CHAR_NUL) begin
            ev.has_prim  = 1'b1;
            ev.prim_kind = KIND_STR_END;
            ev.prim_arg  = ARG_W'(cursor_q);
            if (aligned) begin
              phase_d  = na_phase;
              cursor_d = na_found;
              req_d    = na_req;
              fl_d     = '0;
              gather_d = '0;
              ev.skip_start = ARG_W'(na_base);
              ev.skip_cnt   = SKIP_W'(na_cnt);
            end else begin
              phase_d  = PH_STR_PAD;
              cursor_d = na_base;
            end
          end else if (fl_q < FLW'(STRING_KEEP)) begin
            ev.has_prim   = 1'b1;
            ev.prim_kind  = KIND_STR_CHAR;
            ev.prim_value = VALUE_W'(in_byte_i);
            ev.prim_arg   = ARG_W'(cursor_q);
            fl_d          = fl_q + FLW'(1);
          end
        end
        PH_TAG_PAD, PH_STR_PAD: begin
          if (aligned) begin
            phase_d  = na_phase;
            cursor_d = na_found;
            req_d    = na_req;
            fl_d     = '0;
            gather_d = '0;
            ev.skip_start = ARG_W'(na_base);
            ev.skip_cnt   = SKIP_W'(na_cnt);
          end
        end
        default: begin
        end
      endcase
    end

    if (end_of_packet_i) begin
      ev.has_status = 1'b1;
      if (err_d != ERR_NONE) begin
        ev.status = err_d;
      end else begin
        case (phase_d)
          PH_ADDR:     ev.status = ERR_ADDR_LONG;
          PH_ADDR_PAD: ev.status = ERR_NO_TAG;
          PH_TAG:      ev.status = (tag_total_d == '0) ? ERR_NO_TAG : ERR_TAG_SHORT;
          PH_TAG_PAD:  ev.status = ERR_TAG_SHORT;
          PH_WORD:     ev.status = ERR_ARG_SHORT;
          PH_STR:      ev.status = ERR_ARG_SHORT;
          default:     ev.status = (req_d > bp_d) ? ERR_ARG_SHORT : ERR_NONE;
        endcase
      end
      // Clear for the next datagram
      phase_d     = PH_ADDR;
      bp_d        = '0;
      req_d       = '0;
      fl_d        = '0;
      tag_total_d = '0;
      tag_count_d = '0;
      cursor_d    = '0;
      gather_d    = '0;
      err_d       = ERR_NONE;
    end
  end

  assign ev_o       = ev;
  assign ev_valid_o = ev.has_prim || (ev.skip_cnt != '0) || ev.has_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ADDR;
      bp_q        <= '0;
      req_q       <= '0;
      fl_q        <= '0;
      tag_total_q <= '0;
      tag_count_q <= '0;
      cursor_q    <= '0;
      gather_q    <= '0;
      err_q       <= ERR_NONE;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      bp_q        <= bp_d;
      req_q       <= req_d;
      fl_q        <= fl_d;
      tag_total_q <= tag_total_d;
      tag_count_q <= tag_count_d;
      cursor_q    <= cursor_d;
      gather_q    <= gather_d;
      err_q       <= err_d;
    end
  end

  // Tag kinds are read only below the tag count, so they need no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      skip_q  <= skip_d;
      str_q   <= str_d;
      float_q <= float_d;
    end
  end

endmodule

[rtl/core/omp_queue.sv]
module omp_queue
  import omp_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  omp_event_t wr_data_i,
  output logic       full_o,
  input  logic       rd_en_i,
  output omp_event_t rd_data_o,
  output logic       empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  omp_event_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/omp_back.sv]
module omp_back
  import omp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  omp_event_t  ev_i,
  input  logic        ev_valid_i,
  output logic        ev_take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output omp_result_t res_o
);

  logic              prim_done_q;
  logic [SKIP_W-1:0] skip_done_q;
  logic              out_valid_q;
  omp_result_t       res_q;

  logic              sel_prim, sel_skip;
  logic              more;
  logic              load;
  omp_result_t       res_d;

  assign sel_prim = ev_i.has_prim && !prim_done_q;
  assign sel_skip = !sel_prim && (skip_done_q != ev_i.skip_cnt);
  assign load     = ev_valid_i && (!out_valid_q || pop_i);

  always_comb begin
    res_d = '0;
    res_d.kind       = KIND_OK;
    res_d.error_code = ERR_NONE;
    if (sel_prim) begin
      res_d.kind      = ev_i.prim_kind;
      res_d.value     = ev_i.prim_value;
      res_d.arg_index = ev_i.prim_arg;
      more = (ev_i.skip_cnt != '0) || ev_i.has_status;
    end else if (sel_skip) begin
      res_d.kind      = KIND_SKIPPED;
      res_d.arg_index = ARG_W'(ev_i.skip_start + ARG_W'(skip_done_q));
      more = ((skip_done_q + SKIP_W'(1)) != ev_i.skip_cnt) || ev_i.has_status;
    end else begin
      res_d.kind       = (ev_i.status != ERR_NONE) ? KIND_ERROR : KIND_OK;
      res_d.error_code = ev_i.status;
      more = 1'b0;
    end
    res_d.last_result = !more;
  end

  // Retire the queue entry with its final result
  assign ev_take_o = load && !more;
  assign empty_o   = !out_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_done_q <= 1'b0;
      skip_done_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (!more) begin
          prim_done_q <= 1'b0;
          skip_done_q <= '0;
        end else if (sel_prim) begin
          prim_done_q <= 1'b1;
        end else begin
          skip_done_q <= skip_done_q + SKIP_W'(1);
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/core/osc_message_parser_top.sv]
// Parser for one OSC datagram, fed one byte per cycle while full is low. The
// parser front end takes a byte at every edge where push is high and full is
// low, walks the address, the type tag string and up to MAX_ARGS arguments,
// and writes what the byte produced into a four-entry queue. The back end
// turns each queue entry into results, one per cycle while pop keeps up,
// through an output register: result ports are valid while empty is low and
// advance on pop. The results of a byte pass through the queue and then the
// output register. Most bytes cause at most one result, so the block sustains
// one byte per cycle while pop keeps up; a byte that passes over skipped tags,
// or that ends the datagram, causes several results (up to nine) and holds
// the back end, and full rises once the queue fills. The final result of each
// byte carries last_result, and the final byte of a datagram always ends with
// an ok or error status.
module osc_message_parser_top
  import omp_pkg::*;
#(
  parameter int MAX_PACKET  = MaxPacketDef,
  parameter int ADDR_BYTES  = AddrBytesDef,
  parameter int TAG_BYTES   = TagBytesDef,
  parameter int MAX_ARGS    = MaxArgsDef,
  parameter int STRING_KEEP = StringKeepDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_packet_i,
  output logic               empty,
  input  logic               pop,
  output logic [KIND_W-1:0]  kind_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [ARG_W-1:0]   arg_index_o,
  output logic [ERR_W-1:0]   error_code_o,
  output logic               last_result_o
);

  logic        accept;
  omp_event_t  ev_in, ev_head;
  logic        ev_in_valid;
  logic        q_empty;
  logic        ev_take;
  omp_result_t res;

  assign accept = push && !full;

  omp_front #(
    .MAX_PACKET (MAX_PACKET),
    .ADDR_BYTES (ADDR_BYTES),
    .TAG_BYTES  (TAG_BYTES),
    .MAX_ARGS   (MAX_ARGS),
    .STRING_KEEP(STRING_KEEP)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .ev_o           (ev_in),
    .ev_valid_o     (ev_in_valid)
  );

  omp_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept && ev_in_valid),
    .wr_data_i(ev_in),
    .full_o   (full),
    .rd_en_i  (ev_take),
    .rd_data_o(ev_head),
    .empty_o  (q_empty)
  );

  omp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_i      (ev_head),
    .ev_valid_i(!q_empty),
    .ev_take_o (ev_take),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign kind_o        = res.kind;
  assign value_o       = res.value;
  assign arg_index_o   = res.arg_index;
  assign error_code_o  = res.error_code;
  assign last_result_o = res.last_result;

endmodule

[rtl/core/omp_checker.sv]
module omp_checker
  import omp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [KIND_W-1:0]  kind_o,
  input logic [VALUE_W-1:0] value_o,
  input logic [ARG_W-1:0]   arg_index_o,
  input logic [ERR_W-1:0]   error_code_o,
  input logic               last_result_o
);

  // Hold a waiting result until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(value_o) &&
                       $stable(arg_index_o) && $stable(error_code_o) &&
                       $stable(last_result_o))
    else $error("result changed while stalled");

  // A status closes the byte's results, and its code matches its kind
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == KIND_OK || kind_o == KIND_ERROR) |->
      last_result_o && (arg_index_o == '0) &&
      ((kind_o == KIND_OK) == (error_code_o == ERR_NONE)))
    else $error("status result malformed");

  a_code_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != KIND_ERROR |-> error_code_o == ERR_NONE)
    else $error("error code outside an error result");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (kind_o == KIND_STR_END || kind_o == KIND_SKIPPED ||
               kind_o == KIND_OK || kind_o == KIND_ERROR) |-> value_o == '0)
    else $error("marker result carries a value");

endmodule

bind osc_message_parser_top omp_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .kind_o       (kind_o),
  .value_o      (value_o),
  .arg_index_o  (arg_index_o),
  .error_code_o (error_code_o),
  .last_result_o(last_result_o)
);

[tb/osc_message_parser_top_tb.sv]
`timescale 1ns / 100ps

module osc_message_parser_top_tb;
  import omp_pkg::*;

  typedef enum logic [2:0] {
    SEG_ADDR,
    SEG_ADDR_PAD,
    SEG_TAGS,
    SEG_TAG_PAD,
    SEG_WORD,
    SEG_STRING,
    SEG_STR_PAD,
    SEG_DONE
  } seg_e;

  typedef enum logic [1:0] {
    TAG_INT,
    TAG_FLOAT,
    TAG_STRING,
    TAG_OTHER
  } arg_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // Tag letter the parser does not decode
  localparam logic [7:0] CHAR_T = 8'h54;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               push            = 1'b0;
  logic               full;
  logic [7:0]         in_byte_i       = 8'h00;
  logic               end_of_packet_i = 1'b0;
  logic               empty;
  logic               pop             = 1'b0;
  logic [KIND_W-1:0]  kind_o;
  logic [VALUE_W-1:0] value_o;
  logic [ARG_W-1:0]   arg_index_o;
  logic [ERR_W-1:0]   error_code_o;
  logic               last_result_o;

  osc_message_parser_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .arg_index_o    (arg_index_o),
    .error_code_o   (error_code_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Parser state as predicted
  seg_e        seg;
  int          pos;
  int          fld_len;
  int          tag_len;
  int          tag_n;
  int          arg_cur;
  int          need_len;
  arg_kind_e   tag_kind [MaxArgsDef];
  logic [23:0] gather;
  err_e        latched;

  omp_result_t byte_results[$];
  omp_result_t expected_results[$];
  byte_req_t   datagram_bytes[$];
  logic [7:0]  dg[$];
  logic [7:0]  pad_byte = 8'h00;
  int          mismatches = 0;
  int          drv_wait;
  int          drv_quiet;
  int          mon_wait;
  int          mon_quiet;

  function automatic void clear_parser();
    seg      = SEG_ADDR;
    pos      = 0;
    fld_len  = 0;
    tag_len  = 0;
    tag_n    = 0;
    arg_cur  = 0;
    need_len = 0;
    gather   = '0;
    latched  = ERR_NONE;
    foreach (tag_kind[i]) tag_kind[i] = TAG_INT;
  endfunction

  function automatic void add_result(input kind_e k, input logic [VALUE_W-1:0] v,
                                     input int arg, input err_e e);
    omp_result_t r;
    r.kind        = k;
    r.value       = v;
    r.arg_index   = arg[ARG_W-1:0];
    r.error_code  = e;
    r.last_result = 1'b0;
    byte_results.push_back(r);
  endfunction

  // Step to the next parsed argument, marking skipped tags on the way.
  function automatic void advance_arg();
    while (arg_cur < tag_n && arg_cur < MaxArgsDef && tag_kind[arg_cur] == TAG_OTHER) begin
      add_result(KIND_SKIPPED, '0, arg_cur, ERR_NONE);
      if (pos + 4 > need_len) need_len = pos + 4;
      arg_cur++;
    end
    fld_len = 0;
    gather  = '0;
    if (arg_cur < tag_n && arg_cur < MaxArgsDef) begin
      seg = (tag_kind[arg_cur] == TAG_STRING) ? SEG_STRING : SEG_WORD;
    end else begin
      seg = SEG_DONE;
    end
  endfunction

  function automatic err_e final_status();
    if (latched != ERR_NONE) return latched;
    case (seg)
      SEG_ADDR:             return ERR_ADDR_LONG;
      SEG_ADDR_PAD:         return ERR_NO_TAG;
      SEG_TAGS:             return (tag_len == 0) ? ERR_NO_TAG : ERR_TAG_SHORT;
      SEG_TAG_PAD:          return ERR_TAG_SHORT;
      SEG_WORD, SEG_STRING: return ERR_ARG_SHORT;
      default:              return (need_len > pos) ? ERR_ARG_SHORT : ERR_NONE;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eop);
    logic        aligned;
    err_e        st;
    omp_result_t r;
    byte_results.delete();
    if (latched == ERR_NONE && pos < MaxPacketDef) begin
      pos++;
      aligned = (pos % 4) == 0;
      case (seg)
        SEG_ADDR: begin
          if (b == CHAR_NUL) begin
            seg = aligned ? SEG_TAGS : SEG_ADDR_PAD;
          end else if (pos >= AddrBytesDef) begin
            latched = ERR_ADDR_LONG;
          end else begin
            add_result(KIND_ADDR_CHAR, {24'h0, b}, 0, ERR_NONE);
          end
        end
        SEG_ADDR_PAD: begin
          if (aligned) seg = SEG_TAGS;
        end
        SEG_TAGS: begin
          if (tag_len == 0) begin
            if (b != CHAR_COMMA) latched = ERR_NO_COMMA;
            else tag_len = 1;
          end else if (b == CHAR_NUL) begin
            if (aligned) advance_arg();
            else seg = SEG_TAG_PAD;
          end else if (tag_len >= TagBytesDef - 1) begin
            latched = ERR_TAG_LONG;
          end else begin
            if (tag_n < MaxArgsDef) begin
              if (b == CHAR_I) tag_kind[tag_n] = TAG_INT;
              else if (b == CHAR_F) tag_kind[tag_n] = TAG_FLOAT;
              else if (b == CHAR_S) tag_kind[tag_n] = TAG_STRING;
              else tag_kind[tag_n] = TAG_OTHER;
              tag_n++;
            end
            tag_len++;
          end
        end
        SEG_TAG_PAD, SEG_STR_PAD: begin
          if (aligned) advance_arg();
        end
        SEG_WORD: begin
          if (fld_len < 3) begin
            gather = {gather[15:0], b};
            fld_len++;
          end else begin
            add_result(tag_kind[arg_cur] == TAG_FLOAT ? KIND_FLOAT : KIND_INT,
                       {gather, b}, arg_cur, ERR_NONE);
            arg_cur++;
            advance_arg();
          end
        end
        SEG_STRING: begin
          if (b == CHAR_NUL) begin
            add_result(KIND_STR_END, '0, arg_cur, ERR_NONE);
            arg_cur++;
            if (aligned) advance_arg();
            else seg = SEG_STR_PAD;
          end else if (fld_len < StringKeepDef) begin
            add_result(KIND_STR_CHAR, {24'h0, b}, arg_cur, ERR_NONE);
            fld_len++;
          end
        end
        default: ;
      endcase
    end
    if (eop) begin
      st = final_status();
      add_result(st != ERR_NONE ? KIND_ERROR : KIND_OK, '0, 0, st);
      clear_parser();
    end
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last_result = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    omp_result_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d value %08h", kind_o, value_o));
    end else begin
      want = expected_results.pop_front();
      if (kind_o !== want.kind || value_o !== want.value || arg_index_o !== want.arg_index ||
          error_code_o !== want.error_code || last_result_o !== want.last_result) begin
        flag_mismatch($sformatf(
          "got kind %0d value %08h arg %0d err %0d last %0b, want %0d %08h %0d %0d %0b",
          kind_o, value_o, arg_index_o, error_code_o, last_result_o,
          want.kind, want.value, want.arg_index, want.error_code, want.last_result));
      end
    end
  endtask

  // Datagram assembly
  function automatic void put_b(input logic [7:0] b);
    dg.push_back(b);
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) dg.push_back(s[i]);
  endfunction

  function automatic void put_run(input int n, input logic [7:0] b);
    repeat (n) dg.push_back(b);
  endfunction

  function automatic void put_rand_chars(input int n);
    repeat (n) dg.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic void put_rand_any(input int n);
    repeat (n) dg.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Terminate a string and pad it to a word boundary
  function automatic void put_term();
    dg.push_back(CHAR_NUL);
    while (dg.size() % 4 != 0) dg.push_back(pad_byte);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) dg.push_back(w[8*i +: 8]);
  endfunction

  // Queue the datagram, cut to keep bytes when keep is nonzero
  function automatic void send_dg(input int keep);
    byte_req_t q;
    if (keep > 0) begin
      while (dg.size() > keep) void'(dg.pop_back());
    end
    foreach (dg[i]) begin
      q.data = dg[i];
      q.last = (i == dg.size() - 1);
      datagram_bytes.push_back(q);
    end
    dg.delete();
  endfunction

  function automatic void random_datagram();
    int         k;
    int         pick;
    int         keep;
    logic [7:0] tags[$];
    logic [31:0] w;
    keep = 0;
    if ($urandom_range(0, 99) < 8) begin
      put_rand_any($urandom_range(1, 24));
    end else begin
      pad_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      put_str("/");
      put_rand_chars($urandom_range(0, 10));
      put_term();
      put_b(CHAR_COMMA);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: tags.push_back(CHAR_I);
          3, 4:    tags.push_back(CHAR_F);
          5, 6, 7: tags.push_back(CHAR_S);
          default: tags.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      foreach (tags[i]) put_b(tags[i]);
      put_term();
      for (k = 0; k < tags.size() && k < MaxArgsDef; k++) begin
        if (tags[k] == CHAR_I || tags[k] == CHAR_F) begin
          case ($urandom_range(0, 5))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            2:       w = 32'h8000_0000;
            default: w = $urandom();
          endcase
          put_word(w);
        end else if (tags[k] == CHAR_S) begin
          put_rand_chars($urandom_range(0, 9));
          put_term();
        end
      end
      if ($urandom_range(0, 2) == 0) put_rand_any($urandom_range(1, 6));
      pad_byte = 8'h00;
      pick = $urandom_range(0, 99);
      if (pick < 18) keep = $urandom_range(1, dg.size());
      else if (pick < 28) dg[$urandom_range(0, dg.size() - 1)] = 8'($urandom_range(0, 255));
    end
    send_dg(keep);
  endfunction

  // Byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      drv_wait  = 0;
      drv_quiet = 0;
      clear_parser();
    end else if (!(push && full)) begin
      if (push) begin
        parse_byte(in_byte_i, end_of_packet_i);
        void'(datagram_bytes.pop_front());
        if (drv_quiet > 0) begin
          drv_quiet--;
          drv_wait = 0;
        end else begin
          drv_wait = $urandom_range(0, 3);
          if ($urandom_range(0, 31) == 0) drv_quiet = 40;
        end
      end
      if (drv_wait == 0 && datagram_bytes.size() > 0) begin
        push            <= 1'b1;
        in_byte_i       <= datagram_bytes[0].data;
        end_of_packet_i <= datagram_bytes[0].last;
      end else begin
        push <= 1'b0;
        if (drv_wait > 0) drv_wait--;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      mon_wait  = 0;
      mon_quiet = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
        if (mon_quiet > 0) begin
          mon_quiet--;
          mon_wait = 0;
        end else begin
          mon_wait = $urandom_range(0, 3);
          if ($urandom_range(0, 31) == 0) mon_quiet = 40;
        end
      end
      if (mon_wait == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= 1'b0;
        mon_wait--;
      end
    end
  end

  initial begin
    int dir_n;

    // Shortest message, no arguments
    put_str("/"); put_term(); put_str(","); put_term(); send_dg(0);
    // Word extremes and string bytes at both ends of the range
    put_str("/osc/ctl"); put_term(); put_str(",iiffs"); put_term();
    put_word(32'h0000_0000); put_word(32'hFFFF_FFFF);
    put_word(32'h7F80_0000); put_word(32'h8000_0000);
    put_b(8'hFF); put_b(8'h01); put_b(8'h80); put_term(); send_dg(0);
    // Skipped tags with enough bytes behind them, then without
    put_str("/x"); put_term(); put_str(",TiT"); put_term();
    put_word(32'h1234_5678); put_run(4, 8'h00); send_dg(0);
    put_str("/x"); put_term(); put_str(",TiT"); put_term();
    put_word(32'h1234_5678); send_dg(0);
    // Longest result bursts on one byte
    put_str("/x"); put_term(); put_b(CHAR_COMMA); put_run(8, CHAR_T); put_term(); send_dg(0);
    put_str("/x"); put_term(); put_b(CHAR_COMMA); put_b(CHAR_I); put_run(7, CHAR_T);
    put_term(); put_word(32'hCAFE_F00D); send_dg(0);
    // More tags than argument slots
    put_str("/x"); put_term(); put_b(CHAR_COMMA); put_run(11, CHAR_I); put_term();
    repeat (8) put_word($urandom()); put_run(3, 8'h11); send_dg(0);
    // Longest address that fits, then one too long
    put_rand_chars(255); put_term(); put_str(",f"); put_term();
    put_word(32'h3F80_0000); send_dg(0);
    put_run(260, 8'h41); put_term(); put_str(",i"); put_term(); put_word(32'h1); send_dg(0);
    // Ends inside the address, its padding, and before the tag
    put_str("/ab"); put_term(); send_dg(3);
    put_str("/a"); put_term(); send_dg(3);
    put_str("/ab"); put_term(); send_dg(4);
    // Tag string without the comma
    put_str("/a"); put_term(); put_str("if"); put_term(); put_word(32'h5); send_dg(0);
    // Tag string one too long, then the longest one allowed
    put_str("/a"); put_term(); put_b(CHAR_COMMA); put_run(63, CHAR_I); put_term();
    send_dg(0);
    put_str("/a"); put_term(); put_b(CHAR_COMMA); put_run(62, CHAR_F); put_term();
    repeat (8) put_word($urandom()); send_dg(0);
    // Tag unterminated, and its padding cut
    put_str("/a"); put_term(); put_str(",ii"); send_dg(0);
    put_str("/a"); put_term(); put_str(",i"); put_term(); send_dg(7);
    // Word cut short, string without NUL
    put_str("/a"); put_term(); put_str(",i"); put_term(); put_word(32'hABCD_EF01); send_dg(10);
    put_str("/a"); put_term(); put_str(",s"); put_term(); put_str("abc"); send_dg(0);
    // String padding cut short with a tag still pending
    put_str("/a"); put_term(); put_str(",ss"); put_term(); put_str("ab"); put_b(CHAR_NUL);
    send_dg(0);
    // String longer than what is kept
    put_str("/a"); put_term(); put_str(",s"); put_term(); put_run(300, 8'h71); put_term();
    send_dg(0);
    // Datagrams past the packet limit: trailing bytes, and a string whose NUL is dropped
    put_str("/a"); put_term(); put_str(",i"); put_term(); put_word(32'h7);
    put_rand_any(4100); send_dg(0);
    put_str("/a"); put_term(); put_str(",s"); put_term(); put_run(4100, 8'h7A);
    put_run(10, 8'h00); send_dg(0);
    // One-byte datagrams
    put_b(8'h00); send_dg(0);
    put_b(8'hFF); send_dg(0);
    // Empty address and empty string
    put_term(); put_str(",s"); put_term(); put_term(); send_dg(0);
    // Nonzero padding bytes
    pad_byte = 8'hA5;
    put_str("/pad"); put_term(); put_str(",sf"); put_term(); put_str("x"); put_term();
    put_word(32'h4049_0FDB); send_dg(0);
    pad_byte = 8'h00;

    dir_n = datagram_bytes.size();
    while (datagram_bytes.size() < dir_n + 500) random_datagram();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (datagram_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("osc_message_parser_top_tb: clean");
    end else begin
      $display("osc_message_parser_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("osc_message_parser_top_tb: errors");
    $finish;
  end

endmodule
